// File: rtl/pid_position_incremental_assert.svh
// Assertion macros for the PID channel checker.
// Depends on nothing; included by the checker file only.
`ifndef PID_POSITION_INCREMENTAL_ASSERT_SVH
`define PID_POSITION_INCREMENTAL_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off in reset.
`define PIDPI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pid_position_incremental: property failed");

// Next-cycle implication, sampled on the rising clock edge, off in reset.
`define PIDPI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pid_position_incremental: property failed");

`endif

// File: rtl/pidpi_pkg.sv
// Shared types and constants for the PID channel.
// No dependencies; imported by the register file and the top level.
package pidpi_pkg;

    localparam int GAIN_W    = 16;
    localparam int GD100_W   = 23;
    localparam int LIMIT_W   = 15;
    localparam int ERR_W     = 17;
    localparam int INTEG_W   = 16;
    localparam int OUT_W     = 24;
    localparam int SUM_W     = 45;
    localparam int FRAC_BITS = 8;
    localparam int CFG_IDX_W = 3;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INT_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INC_MODE  = 3'd4;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd500;

    localparam logic [OUT_W-1:0] OUT_POS_MAX = 24'h7FFFFF;
    localparam logic [OUT_W-1:0] OUT_NEG_MAX = 24'h800000;

    typedef struct packed {
        logic [GAIN_W-1:0]  gain_p;
        logic [GAIN_W-1:0]  gain_i;
        logic [GAIN_W-1:0]  gain_d;
        logic [GD100_W-1:0] gain_d_x100;
        logic [LIMIT_W-1:0] integral_limit;
        logic               incremental_mode;
    } cfg_t;

endpackage

// File: rtl/pidpi_item_if.sv
// Input item channel: command, setpoint and measurement.
// No dependencies.
interface pidpi_item_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic signed [15:0] target;
    logic signed [15:0] measure;

    modport source (output valid, output cmd, output target, output measure, input ready);
    modport sink   (input valid, input cmd, input target, input measure, output ready);
endinterface

// File: rtl/pidpi_result_if.sv
// Result channel: saturated drive value and saturation flag.
// No dependencies.
interface pidpi_result_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] control_out;
    logic               out_saturated;

    modport source (output valid, output control_out, output out_saturated, input ready);
    modport sink   (input valid, input control_out, input out_saturated, output ready);
endinterface

// File: rtl/pidpi_cfg_if.sv
// Configuration write channel: register index and write data.
// No dependencies.
interface pidpi_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/pidpi_cfg_regs.sv
// Configuration register file for the PID channel.
// Depends on pidpi_pkg and pidpi_cfg_if.
module pidpi_cfg_regs (
    input  logic              clk,
    input  logic              rst_n,
    pidpi_cfg_if.sink         cfg,
    output pidpi_pkg::cfg_t   regs
);
    import pidpi_pkg::*;

    cfg_t              regs_reg;
    cfg_t              regs_next;
    logic [GD100_W-1:0] gd_ext;
    logic [GD100_W-1:0] gd_x100;

    // Writes are always taken
    assign cfg.ready = 1'b1;

    // 100 = 64 + 32 + 4; keep the scaled gain ready for the derivative product
    assign gd_ext  = GD100_W'(cfg.data);
    assign gd_x100 = (gd_ext << 6) + (gd_ext << 5) + (gd_ext << 2);

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_GAIN_P:
                begin
                    regs_next.gain_p = cfg.data;
                end
                REG_GAIN_I:
                begin
                    regs_next.gain_i = cfg.data;
                end
                REG_GAIN_D:
                begin
                    regs_next.gain_d      = cfg.data;
                    regs_next.gain_d_x100 = gd_x100;
                end
                REG_INT_LIMIT:
                begin
                    regs_next.integral_limit = cfg.data[LIMIT_W-1:0];
                end
                REG_INC_MODE:
                begin
                    regs_next.incremental_mode = cfg.data[0];
                end
                default:
                begin
                    regs_next = regs_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.gain_p           <= '0;
            regs_reg.gain_i           <= '0;
            regs_reg.gain_d           <= '0;
            regs_reg.gain_d_x100      <= '0;
            regs_reg.integral_limit   <= LIMIT_RESET;
            regs_reg.incremental_mode <= 1'b0;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

    assign regs = regs_reg;

endmodule

// File: rtl/pid_position_incremental.sv
// Channel     | Role | Beat contents
// ------------+------+-------------------------------------------------
// item_in     | sink | cmd (0 step, 1 clear integral), target, measure
// result_out  | src  | control_out (24-bit signed), out_saturated
// cfg         | sink | index (register 0..4), data; always ready
//
// One beat is accepted per cycle unless all stages are full and result_out is
// stalled. Each beat moves through them in order: stage 1 holds the error,
// stage 2 the three gain products, stage 3 the shifted, saturated drive value.
// Reset (rst_n low, asynchronous) empties all three stages and zeroes the error
// history and integral; the integral limit comes up at 500. item_in.ready falls
// only when all three stages are full and result_out is stalled.
//
// Depends on pidpi_pkg, the three channel interfaces and pidpi_cfg_regs.
module pid_position_incremental (
    input  logic       clk,
    input  logic       rst_n,
    pidpi_item_if.sink     item_in,
    pidpi_result_if.source result_out,
    pidpi_cfg_if.sink      cfg
);
    import pidpi_pkg::*;

    cfg_t regs;

    // Stage valid flags and per-stage readiness
    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic s3_valid_reg, s3_valid_next;
    logic s1_ready, s2_ready, s3_ready;
    logic s1_fire;

    // Stage 1 payload
    logic                      s1_clr_reg;
    logic signed [ERR_W-1:0]   s1_err_reg;
    logic signed [ERR_W-1:0]   in_err;

    // Loop state
    logic signed [ERR_W-1:0]   last_err_reg, last_err_next;
    logic signed [ERR_W-1:0]   older_err_reg, older_err_next;
    logic signed [INTEG_W-1:0] integ_reg, integ_next;

    // Stage 1 -> 2 datapath
    logic signed [ERR_W:0]     diff1;
    logic signed [ERR_W+1:0]   diff2;
    logic signed [ERR_W:0]     acc_full;
    logic signed [ERR_W:0]     lim_pos;
    logic signed [ERR_W:0]     lim_neg;
    logic signed [ERR_W:0]     acc_sel;
    logic signed [INTEG_W-1:0] acc_clamped;
    logic signed [GAIN_W:0]    gp_s;
    logic signed [GAIN_W:0]    gi_s;
    logic signed [GD100_W:0]   gd_s;
    logic signed [ERR_W:0]     p_op;
    logic signed [ERR_W:0]     i_op;
    logic signed [ERR_W+1:0]   d_op;
    logic signed [34:0]        p_prod;
    logic signed [34:0]        i_prod;
    logic signed [42:0]        d_prod;

    // Stage 2 payload
    logic                      s2_clr_reg;
    logic signed [34:0]        s2_p_reg;
    logic signed [34:0]        s2_i_reg;
    logic signed [42:0]        s2_d_reg;

    // Stage 2 -> 3 datapath
    logic signed [SUM_W-1:0]   sum;
    logic [SUM_W-FRAC_BITS-1:0] y;
    logic                      sat_hi;
    logic                      sat_lo;
    logic [OUT_W-1:0]          y_sat;

    // Stage 3 payload
    logic [OUT_W-1:0]          s3_out_reg;
    logic                      s3_sat_reg;

    pidpi_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    // A stage takes a new beat when it is empty or its own beat moves on
    assign s3_ready = !s3_valid_reg || result_out.ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s1_fire  = s1_valid_reg && s2_ready;

    assign item_in.ready = s1_ready;

    assign s1_valid_next = s1_ready ? item_in.valid : s1_valid_reg;
    assign s2_valid_next = s2_ready ? s1_valid_reg  : s2_valid_reg;
    assign s3_valid_next = s3_ready ? s2_valid_reg  : s3_valid_reg;

    // Error is formed at 17 bits so that no difference of two inputs wraps
    assign in_err = $signed({item_in.target[15], item_in.target})
                  - $signed({item_in.measure[15], item_in.measure});

    // First and second differences against the history
    assign diff1 = (ERR_W+1)'(s1_err_reg) - (ERR_W+1)'(last_err_reg);
    assign diff2 = (ERR_W+2)'(s1_err_reg) - ((ERR_W+2)'(last_err_reg) <<< 1)
                 + (ERR_W+2)'(older_err_reg);

    // Integral: add at full width, then clamp to the symmetric limit
    assign acc_full = (ERR_W+1)'(integ_reg) + (ERR_W+1)'(s1_err_reg);
    assign lim_pos  = $signed({3'b000, regs.integral_limit});
    assign lim_neg  = -lim_pos;

    always_comb
    begin
        if (acc_full > lim_pos)
        begin
            acc_sel = lim_pos;
        end
        else if (acc_full < lim_neg)
        begin
            acc_sel = lim_neg;
        end
        else
        begin
            acc_sel = acc_full;
        end
    end

    assign acc_clamped = acc_sel[INTEG_W-1:0];

    // Operand selection for the two forms:
    //   positional:  kp*e         + ki*integ + (100*kd)*(e - e1)
    //   incremental: kp*(e - e1)  + ki*e     + kd*(e - 2*e1 + e2)
    assign gp_s = $signed({1'b0, regs.gain_p});
    assign gi_s = $signed({1'b0, regs.gain_i});
    assign gd_s = regs.incremental_mode
                ? $signed({1'b0, (GD100_W)'(regs.gain_d)})
                : $signed({1'b0, regs.gain_d_x100});

    assign p_op = regs.incremental_mode ? diff1 : (ERR_W+1)'(s1_err_reg);
    assign i_op = regs.incremental_mode ? (ERR_W+1)'(s1_err_reg)
                                        : (ERR_W+1)'(acc_clamped);
    assign d_op = regs.incremental_mode ? diff2 : (ERR_W+2)'(diff1);

    assign p_prod = gp_s * p_op;
    assign i_prod = gi_s * i_op;
    assign d_prod = gd_s * d_op;

    // History moves only when the stage 1 beat moves on
    always_comb
    begin
        last_err_next  = last_err_reg;
        older_err_next = older_err_reg;
        integ_next     = integ_reg;
        if (s1_fire)
        begin
            if (s1_clr_reg)
            begin
                integ_next = '0;
            end
            else if (regs.incremental_mode)
            begin
                older_err_next = last_err_reg;
                last_err_next  = s1_err_reg;
            end
            else
            begin
                integ_next    = acc_clamped;
                last_err_next = s1_err_reg;
            end
        end
    end

    // Sum carries eight fraction bits; the arithmetic shift floors it
    assign sum = SUM_W'(s2_p_reg) + SUM_W'(s2_i_reg) + SUM_W'(s2_d_reg);
    assign y   = sum[SUM_W-1:FRAC_BITS];

    // Out of range when the bits above the 24-bit sign do not all match it
    assign sat_hi = !y[SUM_W-FRAC_BITS-1] && (|y[SUM_W-FRAC_BITS-2:OUT_W-1]);
    assign sat_lo =  y[SUM_W-FRAC_BITS-1] && !(&y[SUM_W-FRAC_BITS-2:OUT_W-1]);

    always_comb
    begin
        if (sat_hi)
        begin
            y_sat = OUT_POS_MAX;
        end
        else if (sat_lo)
        begin
            y_sat = OUT_NEG_MAX;
        end
        else
        begin
            y_sat = y[OUT_W-1:0];
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            last_err_reg  <= '0;
            older_err_reg <= '0;
            integ_reg     <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            s3_valid_reg  <= s3_valid_next;
            last_err_reg  <= last_err_next;
            older_err_reg <= older_err_next;
            integ_reg     <= integ_next;
        end
    end

    // Payload: load a stage only when a beat enters it
    always_ff @(posedge clk)
    begin
        if (s1_ready && item_in.valid)
        begin
            s1_clr_reg <= item_in.cmd;
            s1_err_reg <= in_err;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_clr_reg <= s1_clr_reg;
            s2_p_reg   <= p_prod;
            s2_i_reg   <= i_prod;
            s2_d_reg   <= d_prod;
        end
        if (s3_ready && s2_valid_reg)
        begin
            // A clear beat reports zero and no saturation
            s3_out_reg <= s2_clr_reg ? '0 : y_sat;
            s3_sat_reg <= s2_clr_reg ? 1'b0 : (sat_hi || sat_lo);
        end
    end

    assign result_out.valid         = s3_valid_reg;
    assign result_out.control_out   = $signed(s3_out_reg);
    assign result_out.out_saturated = s3_sat_reg;

endmodule

// File: rtl/pidpi_checker.sv
// Port-level checker for the PID channel, bound to the top level.
// Depends on pid_position_incremental_assert.svh.
`include "pid_position_incremental_assert.svh"

module pidpi_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [23:0] control_out,
    input logic        out_saturated
);

    // A stalled result stays offered
    `PIDPI_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

    // A stalled result keeps its value
    `PIDPI_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(control_out) && $stable(out_saturated))

    // A saturated result sits at one of the two range ends
    `PIDPI_ASSERT_NOW(a_sat_end, clk, rst_n, out_valid && out_saturated, (control_out == 24'h7FFFFF) || (control_out == 24'h800000))

    // Input back-pressure only when the output side is backed up
    `PIDPI_ASSERT_NOW(a_in_stall, clk, rst_n, !in_ready, out_valid && !out_ready)

endmodule

bind pid_position_incremental pidpi_checker u_pidpi_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (item_in.ready),
    .out_valid     (result_out.valid),
    .out_ready     (result_out.ready),
    .control_out   (result_out.control_out),
    .out_saturated (result_out.out_saturated)
);

// File: dv/pid_position_incremental_tb.sv
// Self-checking testbench for the PID channel pid_position_incremental.
// Depends on pidpi_pkg, the item, result and configuration channel interfaces
// and the block itself; predicts every drive value and checks it beat by beat.
`timescale 1ns / 1ps

module pid_position_incremental_tb;

    import pidpi_pkg::*;

    // Command and mode codes carried in the beats and registers
    localparam logic CMD_STEP         = 1'b0;
    localparam logic CMD_CLEAR        = 1'b1;
    localparam logic MODE_POSITIONAL  = 1'b0;
    localparam logic MODE_INCREMENTAL = 1'b1;

    // Indexes past the last register: writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = REG_INC_MODE + 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = {CFG_IDX_W{1'b1}};

    localparam logic [GAIN_W-1:0]  GAIN_MAX  = {GAIN_W{1'b1}};
    localparam logic [GAIN_W-1:0]  GAIN_ONE  = 16'h0100;    // 1.0 in Q8.8
    localparam logic [LIMIT_W-1:0] LIMIT_MAX = {LIMIT_W{1'b1}};

    localparam longint DRIVE_MAX = 64'sd8388607;
    localparam longint DRIVE_MIN = -64'sd8388608;

    localparam int RANDOM_PHASES  = 9;
    localparam int BEATS_PER_PHASE = 150;
    localparam int LONG_HOLD      = 300;   // receiver hold-off used to fill the pipe
    localparam int IDLE_SETTLE    = 4;     // three stages plus a margin
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct {
        logic               cmd;
        logic signed [15:0] target;
        logic signed [15:0] measure;
    } beat_t;

    typedef struct {
        logic signed [OUT_W-1:0] drive;
        logic                    clipped;
    } drive_t;

    logic clk = 1'b0;
    logic rst_n;

    pidpi_item_if   item_if();
    pidpi_result_if result_if();
    pidpi_cfg_if    cfg_if();

    pid_position_incremental u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_if),
        .result_out (result_if),
        .cfg        (cfg_if)
    );

    // Shadow of the configuration registers, at their reset values
    logic [GAIN_W-1:0]  kp_q88      = '0;
    logic [GAIN_W-1:0]  ki_q88      = '0;
    logic [GAIN_W-1:0]  kd_q88      = '0;
    logic [LIMIT_W-1:0] integ_limit = LIMIT_RESET;
    logic               inc_form    = MODE_POSITIONAL;

    // Shadow of the controller state: error history and clamped integral
    logic signed [ERR_W-1:0]   err_last  = '0;
    logic signed [ERR_W-1:0]   err_older = '0;
    logic signed [INTEG_W-1:0] integ_acc = '0;

    beat_t  beats_to_send[$];
    drive_t expected_drive[$];
    beat_t  next_beat;

    int  tx_gap;
    int  rx_hold;
    int  stall_reqs = 0;
    int  stall_seen = 0;
    bit  steady     = 1'b0;   // no idling on either side
    bit  no_gaps    = 1'b0;   // sender never idles
    int  beats_sent     = 0;
    int  clears_sent    = 0;
    int  results_checked = 0;
    int  mismatches     = 0;
    int  cfg_writes     = 0;
    int  settings       = 0;
    int  quiet_cycles   = 0;

    initial begin
        forever #5 clk = ~clk;
    end

    // Work out the drive value for one beat and advance the shadow state.
    function automatic drive_t predict_drive(input logic cmd_bit,
                                             input logic signed [15:0] tgt,
                                             input logic signed [15:0] meas);
        drive_t r;
        longint err;
        longint prev;
        longint acc;
        longint lim;
        longint sum;
        longint y;
        r.drive   = '0;
        r.clipped = 1'b0;
        if (cmd_bit == CMD_CLEAR) begin
            // clear drops the integral only; history is kept
            integ_acc = '0;
            return r;
        end
        err  = longint'(tgt) - longint'(meas);
        prev = longint'(err_last);
        if (inc_form == MODE_INCREMENTAL) begin
            sum = longint'(kp_q88) * (err - prev)
                + longint'(ki_q88) * err
                + longint'(kd_q88) * (err - 2 * prev + longint'(err_older));
            err_older = err_last;
        end else begin
            acc = longint'(integ_acc) + err;
            lim = longint'(integ_limit);
            if (acc > lim)
                acc = lim;
            else if (acc < -lim)
                acc = -lim;
            integ_acc = acc[INTEG_W-1:0];
            sum = longint'(kp_q88) * err
                + longint'(ki_q88) * acc
                + longint'(kd_q88) * (err - prev) * 100;
        end
        err_last = err[ERR_W-1:0];
        // arithmetic shift floors toward minus infinity
        y = sum >>> FRAC_BITS;
        if (y > DRIVE_MAX) begin
            y = DRIVE_MAX;
            r.clipped = 1'b1;
        end else if (y < DRIVE_MIN) begin
            y = DRIVE_MIN;
            r.clipped = 1'b1;
        end
        r.drive = y[OUT_W-1:0];
        return r;
    endfunction

    // Mostly back to back, sometimes a short pause, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return GAIN_MAX;
            2:       return GAIN_W'($urandom_range(0, 512));
            3:       return GAIN_W'($urandom_range(0, 64));
            default: return GAIN_W'($urandom);
        endcase
    endfunction

    function automatic logic [LIMIT_W-1:0] pick_limit();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return LIMIT_MAX;
            2:       return LIMIT_W'($urandom_range(0, 1000));
            default: return LIMIT_W'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_edge_value();
        case ($urandom_range(0, 4))
            0:       return 16'h8000;
            1:       return 16'hFFFF;
            2:       return 16'h0000;
            3:       return 16'h0001;
            default: return 16'h7FFF;
        endcase
    endfunction

    task automatic queue_beat(input logic cmd_bit, input logic signed [15:0] tgt,
                              input logic signed [15:0] meas);
        beat_t b;
        b.cmd     = cmd_bit;
        b.target  = tgt;
        b.measure = meas;
        beats_to_send.push_back(b);
    endtask

    task automatic queue_random_beat();
        beat_t b;
        b.cmd = ($urandom_range(0, 11) == 0) ? CMD_CLEAR : CMD_STEP;
        case ($urandom_range(0, 3))
            0: begin
                b.target  = 16'($urandom);
                b.measure = 16'($urandom);
            end
            1: begin
                // measurement tracking the setpoint: small errors, real dynamics
                b.target  = 16'($urandom);
                b.measure = b.target - 16'($urandom_range(0, 400)) + 16'd200;
            end
            2: begin
                b.target  = 16'($urandom_range(0, 2000)) - 16'd1000;
                b.measure = 16'($urandom_range(0, 2000)) - 16'd1000;
            end
            default: begin
                b.target  = pick_edge_value();
                b.measure = pick_edge_value();
            end
        endcase
        beats_to_send.push_back(b);
    endtask

    // Poll at the falling edge so the driver has settled, then resync.
    task automatic wait_idle();
        @(negedge clk);
        while (beats_to_send.size() != 0 || item_if.valid || expected_drive.size() != 0)
            @(negedge clk);
        @(posedge clk);
        repeat (IDLE_SETTLE) @(posedge clk);
    endtask

    // Offer one register write and hold it until the beat is taken.
    // Valid is left high so back-to-back writes need no second assignment.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do
            @(posedge clk);
        while (!(cfg_if.valid && cfg_if.ready));
        cfg_writes++;
        case (idx)
            REG_GAIN_P:    kp_q88      = data;
            REG_GAIN_I:    ki_q88      = data;
            REG_GAIN_D:    kd_q88      = data;
            REG_INT_LIMIT: integ_limit = data[LIMIT_W-1:0];
            REG_INC_MODE:  inc_form    = data[0];
            default: ;
        endcase
    endtask

    // Write all five registers; junk in the unused upper bits checks masking.
    task automatic apply_setting(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                                 input logic [GAIN_W-1:0] kd, input logic [LIMIT_W-1:0] lim,
                                 input logic mode);
        write_reg(REG_GAIN_P, kp);
        write_reg(REG_GAIN_I, ki);
        write_reg(REG_GAIN_D, kd);
        write_reg(REG_INT_LIMIT, {1'($urandom_range(0, 1)), lim});
        write_reg(REG_INC_MODE, {15'($urandom), mode});
        if ($urandom_range(0, 2) == 0)
            write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), 16'($urandom));
        cfg_if.valid <= 1'b0;
        settings++;
    endtask

    // Driver: present queued beats, predict each one as it is accepted.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            item_if.valid   <= 1'b0;
            item_if.cmd     <= CMD_STEP;
            item_if.target  <= '0;
            item_if.measure <= '0;
            tx_gap = 0;
        end else begin
            if (item_if.valid && item_if.ready) begin
                expected_drive.push_back(predict_drive(item_if.cmd, item_if.target,
                                                       item_if.measure));
                beats_sent++;
                if (item_if.cmd == CMD_CLEAR)
                    clears_sent++;
            end
            // hold the beat while it is stalled; otherwise move on
            if (!item_if.valid || item_if.ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    item_if.valid <= 1'b0;
                end else if (beats_to_send.size() != 0) begin
                    next_beat = beats_to_send.pop_front();
                    item_if.valid   <= 1'b1;
                    item_if.cmd     <= next_beat.cmd;
                    item_if.target  <= next_beat.target;
                    item_if.measure <= next_beat.measure;
                    tx_gap = (steady || no_gaps) ? 0 : pick_gap();
                end else begin
                    item_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result beat against the oldest prediction and
    // throttle ready, including the long hold-off that backs the pipe up.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            result_if.ready <= 1'b0;
            rx_hold = 0;
        end else begin
            if (result_if.valid && result_if.ready) begin
                results_checked++;
                if (expected_drive.size() == 0) begin
                    $error("result beat with no prediction waiting: control_out %0d",
                           result_if.control_out);
                    mismatches++;
                end else begin
                    automatic drive_t want = expected_drive.pop_front();
                    if (result_if.control_out !== want.drive) begin
                        $error("control_out: expected %0d, got %0d",
                               want.drive, result_if.control_out);
                        mismatches++;
                    end
                    if (result_if.out_saturated !== want.clipped) begin
                        $error("out_saturated: expected %0b, got %0b",
                               want.clipped, result_if.out_saturated);
                        mismatches++;
                    end
                end
            end
            if (stall_seen != stall_reqs) begin
                stall_seen = stall_reqs;
                rx_hold = LONG_HOLD;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                result_if.ready <= 1'b0;
            end else begin
                result_if.ready <= 1'b1;
                if (!steady)
                    rx_hold = pick_gap();
            end
        end
    end

    // Watchdog: give up when no channel moves a beat for too long.
    always @(posedge clk) begin
        if (rst_n === 1'b1) begin
            if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready)
                || (cfg_if.valid && cfg_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        // Drive every input to a known value from time zero
        rst_n           = 1'b0;
        item_if.valid   = 1'b0;
        item_if.cmd     = CMD_STEP;
        item_if.target  = '0;
        item_if.measure = '0;
        result_if.ready = 1'b0;
        cfg_if.valid    = 1'b0;
        cfg_if.index    = '0;
        cfg_if.data     = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Integral gain only: the reset limit of 500 and positional form apply
        write_reg(REG_GAIN_I, GAIN_ONE);
        cfg_if.valid <= 1'b0;
        settings++;
        queue_beat(CMD_STEP, 16'sd300, 16'sd0);
        queue_beat(CMD_STEP, 16'sd300, 16'sd0);        // clamps at the limit
        queue_beat(CMD_STEP, -16'sd32768, 16'sd32767); // largest negative error
        queue_beat(CMD_CLEAR, 16'sd1234, -16'sd77);
        queue_beat(CMD_STEP, 16'sd0, 16'sd0);
        wait_idle();

        // Full gains, widest limit: saturate both ways, clear, derivative kick
        apply_setting(GAIN_MAX, GAIN_MAX, GAIN_MAX, LIMIT_MAX, MODE_POSITIONAL);
        queue_beat(CMD_STEP, 16'sd32767, -16'sd32768);
        queue_beat(CMD_STEP, -16'sd32768, 16'sd32767);
        queue_beat(CMD_CLEAR, 16'sd32767, 16'sd32767);
        queue_beat(CMD_STEP, 16'sd0, 16'sd0);
        queue_beat(CMD_STEP, 16'sd0, -16'sd1);
        wait_idle();

        // Incremental form with full gains, history swinging end to end
        apply_setting(GAIN_MAX, GAIN_MAX, GAIN_MAX, LIMIT_MAX, MODE_INCREMENTAL);
        queue_beat(CMD_STEP, 16'sd32767, -16'sd32768);
        queue_beat(CMD_STEP, -16'sd32768, 16'sd32767);
        queue_beat(CMD_STEP, -16'sd32768, 16'sd32767);
        queue_beat(CMD_CLEAR, -16'sd1, 16'sd1);
        queue_beat(CMD_STEP, 16'sd5, 16'sd5);
        wait_idle();

        // Tiny gain and zero limit: floor rounding of negative sums
        apply_setting(16'h0001, '0, '0, '0, MODE_POSITIONAL);
        queue_beat(CMD_STEP, 16'sd0, 16'sd1);
        queue_beat(CMD_STEP, 16'sd1, 16'sd0);
        queue_beat(CMD_STEP, -16'sd255, 16'sd0);
        queue_beat(CMD_STEP, -16'sd257, 16'sd0);
        wait_idle();

        // Random phases, each with its own setting; extremes come first
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0:       apply_setting(GAIN_MAX, GAIN_MAX, GAIN_MAX, LIMIT_MAX,
                                       MODE_POSITIONAL);
                1:       apply_setting('0, '0, '0, '0, MODE_INCREMENTAL);
                2:       apply_setting(GAIN_MAX, GAIN_MAX, GAIN_MAX, pick_limit(),
                                       MODE_INCREMENTAL);
                default: apply_setting(pick_gain(), pick_gain(), pick_gain(), pick_limit(),
                                       1'($urandom_range(0, 1)));
            endcase
            steady  = (ph == 5);
            no_gaps = (ph == 3);
            // keep offering beats while the receiver sits on its hands
            if (ph == 3)
                stall_reqs++;
            for (int n = 0; n < BEATS_PER_PHASE; n++)
                queue_random_beat();
            wait_idle();
        end
        steady  = 1'b0;
        no_gaps = 1'b0;

        // Let any stray result beat show up before the verdict
        repeat (2 * IDLE_SETTLE) @(posedge clk);
        if (expected_drive.size() != 0) begin
            $error("%0d predicted results never arrived", expected_drive.size());
            mismatches++;
        end

        $display("Sent %0d control beats (%0d clears) over %0d register settings, %0d writes.",
                 beats_sent, clears_sent, settings, cfg_writes);
        $display("Checked %0d result beats, %0d mismatches.", results_checked, mismatches);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
